/* sv/srfc_pkg.sv */
// Shared types and constants for the sensor reply frame checker.
// No dependencies; used by every module of the block.
package srfc_pkg;

  localparam int MAX_FRAME = 128;
  localparam int CNT_W     = $clog2(MAX_FRAME);
  localparam int ADDR_BYTES = 4;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hEF;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h01;
  localparam logic [7:0] REPLY_IDENT_RST   = 8'h07;

  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_REPLY_IDENT   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MOD_ERR  = 2'd1;
  localparam logic [1:0] ST_SUM_ERR  = 2'd2;
  localparam logic [1:0] ST_BAD_LEN  = 2'd3;

  typedef enum logic [3:0] {
    PH_HEAD1   = 4'd0,
    PH_HEAD2   = 4'd1,
    PH_ADDR    = 4'd2,
    PH_IDENT   = 4'd3,
    PH_LENHI   = 4'd4,
    PH_LENLO   = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_SUMHI   = 4'd7,
    PH_SUMLO   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  data_byte;
    logic [7:0]  confirm_code;
    logic [1:0]  status;
  } result_t;

endpackage

/* sv/srfc_parser.sv */
// Frame parser: configuration registers, phase machine, running sum.
// Depends on srfc_pkg; produces at most one result per accepted byte.
module srfc_parser
  import srfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        byte_valid,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output result_t     res
);

  logic [7:0] header_first;
  logic [7:0] header_second;
  logic [7:0] reply_ident;

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [15:0]       length_value, length_value_next;
  logic [15:0]       running_sum, running_sum_next;
  logic [7:0]        held_confirm, held_confirm_next;
  logic [7:0]        held_data, held_data_next;
  logic [7:0]        sum_high_rx, sum_high_rx_next;
  logic [15:0]       len_full;
  logic              emit;
  result_t           res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RST;
      header_second <= HEADER_SECOND_RST;
      reply_ident   <= REPLY_IDENT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HEADER_FIRST:  header_first  <= cfg_wdata;
        REG_HEADER_SECOND: header_second <= cfg_wdata;
        REG_REPLY_IDENT:   reply_ident   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    length_value_next = length_value;
    running_sum_next  = running_sum;
    held_confirm_next = held_confirm;
    held_data_next    = held_data;
    sum_high_rx_next  = sum_high_rx;
    emit              = 1'b0;
    res_next          = '0;
    len_full          = {length_value[15:8], rx_byte};
    unique case (phase)
      PH_HEAD2: begin
        if (rx_byte == header_second) begin
          byte_count_next = '0;
          phase_next      = PH_ADDR;
        end else if (rx_byte != header_first) begin
          phase_next = PH_HEAD1;
        end
      end
      PH_ADDR: begin
        byte_count_next = byte_count + 1'b1;
        if (byte_count_next >= CNT_W'(ADDR_BYTES)) phase_next = PH_IDENT;
      end
      PH_IDENT: begin
        if (rx_byte == reply_ident) begin
          running_sum_next  = {8'd0, rx_byte};
          held_confirm_next = '0;
          held_data_next    = '0;
          length_value_next = '0;
          phase_next        = PH_LENHI;
        end else begin
          phase_next = PH_HEAD1;
        end
      end
      PH_LENHI: begin
        length_value_next = {rx_byte, 8'd0};
        running_sum_next  = running_sum + {8'd0, rx_byte};
        phase_next        = PH_LENLO;
      end
      PH_LENLO: begin
        length_value_next = len_full;
        running_sum_next  = running_sum + {8'd0, rx_byte};
        if (len_full < 16'd3 || len_full > 16'(MAX_FRAME)) begin
          emit                  = 1'b1;
          res_next.status       = ST_BAD_LEN;
          res_next.frame_length = len_full;
          phase_next            = PH_HEAD1;
        end else begin
          byte_count_next = '0;
          phase_next      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next = running_sum + {8'd0, rx_byte};
        if (byte_count == CNT_W'(0)) held_confirm_next = rx_byte;
        if (byte_count == CNT_W'(2)) held_data_next = rx_byte;
        byte_count_next = byte_count + 1'b1;
        if (16'(byte_count_next) >= length_value - 16'd2) phase_next = PH_SUMHI;
      end
      PH_SUMHI: begin
        sum_high_rx_next = rx_byte;
        phase_next       = PH_SUMLO;
      end
      PH_SUMLO: begin
        emit                  = 1'b1;
        res_next.confirm_code = held_confirm;
        res_next.data_byte    = (length_value > 16'd3) ? held_data : 8'd0;
        res_next.frame_length = length_value;
        if (sum_high_rx != running_sum[15:8] || rx_byte != running_sum[7:0]) begin
          res_next.status = ST_SUM_ERR;
        end else if (held_confirm != 8'd0) begin
          res_next.status = ST_MOD_ERR;
        end else begin
          res_next.status = ST_OK;
        end
        phase_next = PH_HEAD1;
      end
      default: begin
        // hunting, and any unused phase code
        phase_next = (rx_byte == header_first) ? PH_HEAD2 : PH_HEAD1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEAD1;
      byte_count   <= '0;
      length_value <= '0;
      running_sum  <= '0;
      held_confirm <= '0;
      held_data    <= '0;
      sum_high_rx  <= '0;
      res_valid    <= 1'b0;
    end else begin
      res_valid <= byte_valid & emit;
      if (byte_valid) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        length_value <= length_value_next;
        running_sum  <= running_sum_next;
        held_confirm <= held_confirm_next;
        held_data    <= held_data_next;
        sum_high_rx  <= sum_high_rx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && emit) res <= res_next;
  end

endmodule

/* sv/srfc_out_buf.sv */
// Two-word output buffer between the parser and the result stream.
// Depends on srfc_pkg for the result word type.
module srfc_out_buf
  import srfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_word,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  result_t    slot0, slot1;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (count != 2'd0);
  assign out_word  = slot0;
  // a word can still land while the head waits, so hold ready only when full
  assign space     = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) slot0 <= slot1;
      else if (push)     slot0 <= push_word;
    end else if (push) begin
      if (count == 2'd0) slot0 <= push_word;
      else               slot1 <= push_word;
    end
  end

endmodule

/* sv/sensor_reply_frame_checker.sv */
// Sensor reply frame checker: byte stream in, one result word per frame out.
// Usage:
//   s_tvalid/s_tready/s_tdata carry received serial bytes, one per word.
//   m_tvalid/m_tready/m_tdata carry result words: status, confirmation code,
//   third payload byte and the received length field.
//   cfg_we/cfg_addr/cfg_wdata write header_first (0), header_second (1) and
//   reply_ident (2); write only while no frame is in flight.
// Throughput is one byte per cycle while s_tready is high: the phase machine and
// its 16-bit adder finish each byte combinationally.
// After the closing checksum byte is taken (or the low length byte for a bad
// length), the result word passes through the parser's result register and
// then the output buffer before it shows on m_tvalid/m_tdata.
// A two-word output buffer sits after the parser; s_tready drops only when
// both words are held, so header and payload bytes keep flowing while the
// receiver stalls.
// Reset (rst, synchronous) restores the default header 0xEF 0x01 and reply
// identifier 0x07, empties the output buffer and starts hunting for a header.
module sensor_reply_frame_checker
  import srfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [1:0] status, [9:2] confirm_code,
                                 // [17:10] data_byte, [33:18] frame_length
);

  logic    byte_valid;
  logic    res_valid;
  result_t res;
  result_t out_word;

  assign byte_valid = s_tvalid & s_tready;

  srfc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (byte_valid),
    .rx_byte    (s_tdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  srfc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_word (res),
    .space     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  assign m_tdata = {6'd0, out_word};

endmodule

/* sim/sensor_reply_frame_checker_test.sv */
// Self-checking testbench for sensor_reply_frame_checker: frames and noise in,
// result words out, checked against a predictor of the frame parser kept here.
// Depends on srfc_pkg and the sensor_reply_frame_checker RTL only.
module sensor_reply_frame_checker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import srfc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_BYTES = 60;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  confirm;
    logic [7:0]  third;
    logic [15:0] length;
  } reply_t;

  typedef enum {
    FLAW_NONE, FLAW_SUM_HI, FLAW_SUM_LO, FLAW_IDENT, FLAW_HEAD2, FLAW_RESTART, FLAW_CUT
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_HEADER_FIRST;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  // stimulus and checking state
  logic [7:0] pending_bytes[$];
  reply_t     expected_replies[$];
  logic       byte_fire = 1'b0;
  int         send_gap_pct = 0;
  int         stall_pct = 0;
  int         hold_off_left = 0;
  int         quiet_cycles = 0;
  int         fail_count = 0;

  // predictor copy of the parser
  phase_t      frame_phase = PH_HEAD1;
  logic [15:0] addr_count = '0;
  logic [15:0] pay_count = '0;
  logic [15:0] len_field = '0;
  logic [15:0] csum = '0;
  logic [7:0]  conf_hold = '0;
  logic [7:0]  third_hold = '0;
  logic [7:0]  csum_hi_rx = '0;
  logic [7:0]  cfg_head1 = HEADER_FIRST_RST;
  logic [7:0]  cfg_head2 = HEADER_SECOND_RST;
  logic [7:0]  cfg_ident = REPLY_IDENT_RST;

  sensor_reply_frame_checker u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Advance the predicted parser by one received byte.
  task automatic parse_byte(input logic [7:0] b);
    reply_t r;
    case (frame_phase)
      PH_HEAD2: begin
        if (b == cfg_head2) begin
          addr_count = '0;
          frame_phase = PH_ADDR;
        end else if (b != cfg_head1) begin
          frame_phase = PH_HEAD1;
        end
      end
      PH_ADDR: begin
        addr_count = addr_count + 16'd1;
        if (addr_count >= ADDR_BYTES) frame_phase = PH_IDENT;
      end
      PH_IDENT: begin
        if (b == cfg_ident) begin
          csum = {8'h00, b};
          conf_hold = '0;
          third_hold = '0;
          len_field = '0;
          frame_phase = PH_LENHI;
        end else begin
          frame_phase = PH_HEAD1;
        end
      end
      PH_LENHI: begin
        len_field = {b, 8'h00};
        csum = csum + {8'h00, b};
        frame_phase = PH_LENLO;
      end
      PH_LENLO: begin
        len_field = {len_field[15:8], b};
        csum = csum + {8'h00, b};
        if (len_field < 16'd3 || int'(len_field) > MAX_FRAME) begin
          r.status = ST_BAD_LEN;
          r.confirm = '0;
          r.third = '0;
          r.length = len_field;
          expected_replies.push_back(r);
          frame_phase = PH_HEAD1;
        end else begin
          pay_count = '0;
          frame_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        csum = csum + {8'h00, b};
        if (pay_count == 16'd0) conf_hold = b;
        if (pay_count == 16'd2) third_hold = b;
        pay_count = pay_count + 16'd1;
        if (int'(pay_count) >= int'(len_field) - 2) frame_phase = PH_SUMHI;
      end
      PH_SUMHI: begin
        csum_hi_rx = b;
        frame_phase = PH_SUMLO;
      end
      PH_SUMLO: begin
        if (csum_hi_rx != csum[15:8] || b != csum[7:0]) r.status = ST_SUM_ERR;
        else if (conf_hold != 8'h00) r.status = ST_MOD_ERR;
        else r.status = ST_OK;
        r.confirm = conf_hold;
        r.third = (len_field > 16'd3) ? third_hold : 8'h00;
        r.length = len_field;
        expected_replies.push_back(r);
        frame_phase = PH_HEAD1;
      end
      default: frame_phase = (b == cfg_head1) ? PH_HEAD2 : PH_HEAD1;
    endcase
  endtask

  // Build one frame with the current header and identifier, optionally damaged.
  task automatic queue_frame(input logic [15:0] len, input logic [7:0] confirm,
                             input flaw_t flaw);
    logic [7:0]  frame[$];
    logic [7:0]  b;
    logic [15:0] sum;
    int          k;
    if (flaw == FLAW_RESTART) frame.push_back(cfg_head1);
    frame.push_back(cfg_head1);
    if (flaw == FLAW_HEAD2) begin
      do b = 8'($urandom); while (b == cfg_head1 || b == cfg_head2);
      frame.push_back(b);
    end else begin
      frame.push_back(cfg_head2);
      repeat (ADDR_BYTES) frame.push_back(8'($urandom));
      if (flaw == FLAW_IDENT) begin
        frame.push_back(cfg_ident ^ 8'($urandom_range(1, 255)));
      end else begin
        frame.push_back(cfg_ident);
        frame.push_back(len[15:8]);
        frame.push_back(len[7:0]);
        sum = {8'h00, cfg_ident} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
        if (len >= 16'd3 && int'(len) <= MAX_FRAME) begin
          for (k = 0; k < int'(len) - 2; k++) begin
            b = (k == 0) ? confirm : 8'($urandom);
            frame.push_back(b);
            sum = sum + {8'h00, b};
          end
          if (flaw == FLAW_SUM_HI) sum[15:8] = sum[15:8] ^ 8'($urandom_range(1, 255));
          if (flaw == FLAW_SUM_LO) sum[7:0] = sum[7:0] ^ 8'($urandom_range(1, 255));
          frame.push_back(sum[15:8]);
          frame.push_back(sum[7:0]);
        end
      end
    end
    // truncate: the parser stays mid-frame and eats what follows
    if (flaw == FLAW_CUT && frame.size() > 3) begin
      repeat ($urandom_range(1, frame.size() - 3)) void'(frame.pop_back());
    end
    foreach (frame[i]) pending_bytes.push_back(frame[i]);
  endtask

  task automatic queue_random_frame();
    logic [15:0] len;
    flaw_t       flaw;
    int          r;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(3))
        0: len = 16'($urandom_range(2));
        1: len = 16'(MAX_FRAME + 1);
        2: len = 16'($urandom_range(MAX_FRAME + 1, 65535));
        default: len = 16'hFFFF;
      endcase
    end else if (r < 14) begin
      len = 16'($urandom_range(13, MAX_FRAME));
    end else begin
      len = 16'($urandom_range(3, 12));
    end
    r = $urandom_range(99);
    if (r < 70) flaw = FLAW_NONE;
    else if (r < 75) flaw = FLAW_SUM_HI;
    else if (r < 80) flaw = FLAW_SUM_LO;
    else if (r < 85) flaw = FLAW_IDENT;
    else if (r < 90) flaw = FLAW_HEAD2;
    else if (r < 96) flaw = FLAW_RESTART;
    else flaw = FLAW_CUT;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom));
    end
    queue_frame(len, $urandom_range(1) ? 8'($urandom) : 8'h00, flaw);
  endtask

  task automatic write_regs(input logic [7:0] h1, input logic [7:0] h2,
                            input logic [7:0] ident);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_HEADER_FIRST;
    cfg_wdata <= h1;
    @(negedge clk);
    cfg_addr <= REG_HEADER_SECOND;
    cfg_wdata <= h2;
    @(negedge clk);
    cfg_addr <= REG_REPLY_IDENT;
    cfg_wdata <= ident;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every byte is taken, flush any cut frame back to hunting, wait
  // for every result, then let the output buffer and the parser's result
  // register settle.
  task automatic drain();
    logic [7:0] filler;
    filler = 8'h00;
    while (filler == cfg_head1 || filler == cfg_head2) filler = filler + 8'd1;
    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (frame_phase != PH_HEAD1) begin
      pending_bytes.push_back(filler);
      @(posedge clk);
      while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
    end
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic queue_phase_bytes();
    int goal;
    goal = pending_bytes.size() + PHASE_BYTES;
    while (pending_bytes.size() < goal) queue_random_frame();
  endtask

  // Sender: hold the word until taken, then offer the next one or idle.
  always @(negedge clk) begin
    if (!s_tvalid || byte_fire) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_bytes.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    byte_fire = s_tvalid && s_tready;
    if (rst) begin
      frame_phase = PH_HEAD1;
      addr_count = '0;
      pay_count = '0;
      len_field = '0;
      csum = '0;
      conf_hold = '0;
      third_hold = '0;
      csum_hi_rx = '0;
      cfg_head1 = HEADER_FIRST_RST;
      cfg_head2 = HEADER_SECOND_RST;
      cfg_ident = REPLY_IDENT_RST;
      quiet_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_HEADER_FIRST:  cfg_head1 = cfg_wdata;
          REG_HEADER_SECOND: cfg_head2 = cfg_wdata;
          REG_REPLY_IDENT:   cfg_ident = cfg_wdata;
          default: ;
        endcase
      end
      if (byte_fire) parse_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.confirm = m_tdata[9:2];
        got.third = m_tdata[17:10];
        got.length = m_tdata[33:18];
        if (expected_replies.size() == 0) begin
          note_failure($sformatf("result word with none expected: %h", m_tdata));
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status || got.confirm !== want.confirm ||
              got.third !== want.third || got.length !== want.length ||
              m_tdata[39:34] !== 6'd0) begin
            note_failure($sformatf(
              "expected status %0d confirm %h data %h length %h, got %0d %h %h %h pad %b",
              want.status, want.confirm, want.third, want.length,
              got.status, got.confirm, got.third, got.length, m_tdata[39:34]));
          end
        end
      end
      quiet_cycles = (byte_fire || (m_tvalid && m_tready)) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames on the reset header and identifier, no idling
    queue_frame(16'd3, 8'h00, FLAW_NONE);
    queue_frame(16'd4, 8'hFF, FLAW_NONE);
    queue_frame(16'd5, 8'h00, FLAW_NONE);
    queue_frame(16'd0, 8'h00, FLAW_NONE);
    queue_frame(16'd2, 8'h00, FLAW_NONE);
    queue_frame(16'(MAX_FRAME + 1), 8'h00, FLAW_NONE);
    queue_frame(16'hFFFF, 8'h00, FLAW_NONE);
    queue_frame(16'd5, 8'h00, FLAW_SUM_HI);
    queue_frame(16'd5, 8'h01, FLAW_SUM_LO);
    queue_frame(16'd5, 8'h00, FLAW_IDENT);
    queue_frame(16'd4, 8'h80, FLAW_RESTART);
    queue_frame(16'd4, 8'h00, FLAW_HEAD2);
    queue_frame(16'd3, 8'h55, FLAW_NONE);
    drain();

    // extreme register values; long hold-off while the sender keeps going
    write_regs(8'h00, 8'hFF, 8'hFF);
    @(posedge clk);
    hold_off_left = HOLD_OFF_CYCLES;
    queue_frame(16'(MAX_FRAME), 8'h00, FLAW_NONE);
    queue_phase_bytes();
    drain();

    write_regs(8'hFF, 8'h00, 8'h00);
    @(posedge clk);
    send_gap_pct = 57;
    queue_phase_bytes();
    drain();

    write_regs(8'($urandom), 8'($urandom), 8'($urandom));
    @(posedge clk);
    send_gap_pct = 0;
    stall_pct = 57;
    queue_phase_bytes();
    drain();

    write_regs(HEADER_FIRST_RST, HEADER_SECOND_RST, REPLY_IDENT_RST);
    @(posedge clk);
    send_gap_pct = 18;
    stall_pct = 18;
    queue_phase_bytes();
    drain();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
